// File: rtl/interval_welford_stats_assert.svh
// Assertion macros used by the interval statistics RTL.
`ifndef INTERVAL_WELFORD_STATS_ASSERT_SVH
`define INTERVAL_WELFORD_STATS_ASSERT_SVH
`ifndef ASSERT_OFF
`define IWS_ASSERT_IMPLY(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("interval statistics check failed");
`define IWS_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("interval statistics check failed");
`else
`define IWS_ASSERT_IMPLY(lbl, ante, cons)
`define IWS_ASSERT_NEXT(lbl, ante, cons)
`endif
`endif

// File: rtl/iws_pkg.sv
// Shared types and constants of the interval statistics block.
package iws_pkg;

  localparam int OPC_W = 2;
  localparam int NOW_W = 32;
  localparam int COUNT_W = 32;
  localparam int MEAN_W = 48;
  localparam int SPREAD_W = 64;
  localparam int MAX_W = 32;
  localparam int HALF_W = MEAN_W / 2;
  localparam int PROD_W = 2 * MEAN_W;
  localparam int DIVR_W = 32;
  localparam int STEP_W = 7;
  localparam int MEAN_PAD_W = SPREAD_W - MEAN_W;

  localparam int TIME_WIDTH_DEF = 32;
  localparam int FRAC_BITS_DEF = 16;

  localparam logic [MEAN_W-1:0] MEAN_MAX = '1;
  localparam logic [COUNT_W-1:0] COUNT_MAX = '1;
  localparam logic [STEP_W-1:0] STEP_ONE = STEP_W'(1);
  localparam logic [STEP_W-1:0] MEAN_STEPS = STEP_W'(MEAN_W);
  localparam logic [STEP_W-1:0] SPREAD_STEPS = STEP_W'(SPREAD_W);

  typedef enum logic [1:0] {
    OP_START,
    OP_STOP,
    OP_SAMPLE,
    OP_REPORT
  } iws_op_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_PREP,
    S_DIFF,
    S_MDIV,
    S_MEAN,
    S_DEV,
    S_MUL,
    S_ACC,
    S_VDIV,
    S_EMIT
  } iws_state_t;

  typedef struct packed {
    logic              start;
    logic [STEP_W-1:0] steps;
  } div_cmd_t;

endpackage

// File: rtl/iws_event_if.sv
// Input channel carrying one timer event per beat.
interface iws_event_if;
  logic                       valid;
  logic                       ready;
  logic [iws_pkg::OPC_W-1:0]  opcode;
  logic [iws_pkg::NOW_W-1:0]  now_ticks;

  modport source (output valid, opcode, now_ticks, input ready);
  modport sink (input valid, opcode, now_ticks, output ready);
endinterface

// File: rtl/iws_stats_if.sv
// Output channel carrying one statistics report per beat.
interface iws_stats_if;
  logic                          valid;
  logic                          ready;
  logic [iws_pkg::COUNT_W-1:0]   sample_count;
  logic [iws_pkg::MEAN_W-1:0]    mean_ticks;
  logic [iws_pkg::SPREAD_W-1:0]  variance_ticks;
  logic [iws_pkg::MAX_W-1:0]     max_duration;

  modport source (output valid, sample_count, mean_ticks, variance_ticks, max_duration,
                  input ready);
  modport sink (input valid, sample_count, mean_ticks, variance_ticks, max_duration,
                output ready);
endinterface

// File: rtl/iws_div.sv
// Restoring serial divider, one quotient bit per cycle.
module iws_div (
  input  logic                            clk,
  input  logic                            rst,
  input  iws_pkg::div_cmd_t               cmd,
  input  logic [iws_pkg::SPREAD_W-1:0]    dividend,
  input  logic [iws_pkg::DIVR_W-1:0]      divisor,
  output logic [iws_pkg::SPREAD_W-1:0]    quotient,
  output logic                            done
);

  logic [iws_pkg::SPREAD_W-1:0] dvd;
  logic [iws_pkg::DIVR_W-1:0]   rem;
  logic [iws_pkg::DIVR_W-1:0]   dvr;
  logic [iws_pkg::STEP_W-1:0]   left;
  logic                         busy;

  logic [iws_pkg::DIVR_W:0]     rem_sh;
  logic [iws_pkg::DIVR_W:0]     rem_sub;
  logic                         fits;

  always_comb begin
    rem_sh  = {rem, dvd[iws_pkg::SPREAD_W-1]};
    rem_sub = rem_sh - {1'b0, dvr};
    fits    = rem_sh >= {1'b0, dvr};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= !cmd.start && busy && (left == iws_pkg::STEP_ONE);
      if (cmd.start) begin
        dvd  <= dividend;
        dvr  <= divisor;
        rem  <= '0;
        left <= cmd.steps;
        busy <= 1'b1;
      end else if (busy) begin
        dvd  <= {dvd[iws_pkg::SPREAD_W-2:0], fits};
        rem  <= fits ? rem_sub[iws_pkg::DIVR_W-1:0] : rem_sh[iws_pkg::DIVR_W-1:0];
        left <= left - iws_pkg::STEP_ONE;
        if (left == iws_pkg::STEP_ONE) begin
          busy <= 1'b0;
        end
      end
    end
  end

  assign quotient = dvd;

endmodule

// File: rtl/interval_welford_stats.sv
// Interval statistics tracker: Welford mean and variance over timed intervals.
// Items arrive on the events channel as an opcode and a timestamp in ticks.
// Start latches the timestamp unless the clock already runs, stop clears the
// running flag, and sample, while the clock runs, measures the wrapped interval
// since start, clears the running flag and folds the interval into the count,
// mean, spread sum and maximum. Report sends one beat on the stats channel with
// count, mean, sample variance and maximum, then clears the statistics while
// the running flag and start time stay. A sample runs the 48-step serial
// divider for the mean update and a four-pass 24 by 24 multiplier for the
// spread update. A report runs the 64-step divide of the spread sum when the
// count exceeds one, and skips it otherwise.
// The events channel is ready only while no item is in work. A finished report
// waits in the output register while the next items are taken; another report
// then waits for the receiver before it is loaded. Synchronous reset clears the
// clock state and all statistics and drops any pending report.
`include "interval_welford_stats_assert.svh"

module interval_welford_stats #(
  parameter int TIME_WIDTH = iws_pkg::TIME_WIDTH_DEF,
  parameter int FRAC_BITS  = iws_pkg::FRAC_BITS_DEF
) (
  input  logic              clk,
  input  logic              rst,
  iws_event_if.sink         events,
  iws_stats_if.source       stats
);

  localparam logic [iws_pkg::MEAN_W-1:0] TQ_LIMIT = iws_pkg::MEAN_MAX >> FRAC_BITS;
  localparam int INC_HI = iws_pkg::SPREAD_W + FRAC_BITS;

  iws_pkg::iws_state_t state, state_next;
  iws_pkg::iws_op_t    op;
  iws_pkg::div_cmd_t   div_cmd;

  logic [TIME_WIDTH-1:0]          start_time;
  logic                           clock_running;
  logic [iws_pkg::COUNT_W-1:0]    interval_count;
  logic [iws_pkg::MEAN_W-1:0]     mean_acc;
  logic [iws_pkg::SPREAD_W-1:0]   spread_acc;
  logic [TIME_WIDTH-1:0]          max_seen;

  logic [TIME_WIDTH-1:0]          t_reg;
  logic [iws_pkg::MEAN_W-1:0]     tq_reg;
  logic                           up;
  logic [iws_pkg::MEAN_W-1:0]     dabs;
  logic [iws_pkg::MEAN_W-1:0]     eabs;
  logic [iws_pkg::MEAN_W-1:0]     prod;
  logic [iws_pkg::PROD_W-1:0]     acc;
  logic [2:0]                     k;
  logic                           stats_valid;

  logic                           accept;
  logic                           emit_go;
  logic [TIME_WIDTH-1:0]          now_tw;
  logic [iws_pkg::MEAN_W-1:0]     t48;
  logic [iws_pkg::MEAN_W-1:0]     tq_c;
  logic                           up_c;
  logic [iws_pkg::MEAN_W-1:0]     dabs_c;
  logic [iws_pkg::MEAN_W-1:0]     q_mean;
  logic [iws_pkg::HALF_W-1:0]     a_half;
  logic [iws_pkg::HALF_W-1:0]     b_half;
  logic [1:0]                     pk;
  logic [iws_pkg::PROD_W-1:0]     part;
  logic                           inc_sat;
  logic [iws_pkg::SPREAD_W-1:0]   inc;
  logic [iws_pkg::SPREAD_W:0]     spread_sum;
  logic [iws_pkg::MEAN_W-1:0]     max48;
  logic [iws_pkg::SPREAD_W-1:0]   div_dividend;
  logic [iws_pkg::DIVR_W-1:0]     div_divisor;
  logic [iws_pkg::SPREAD_W-1:0]   div_quot;
  logic                           div_done;

  iws_div u_div (
    .clk      (clk),
    .rst      (rst),
    .cmd      (div_cmd),
    .dividend (div_dividend),
    .divisor  (div_divisor),
    .quotient (div_quot),
    .done     (div_done)
  );

  assign op     = iws_pkg::iws_op_t'(events.opcode);
  assign accept = events.valid && events.ready;
  assign now_tw = TIME_WIDTH'(events.now_ticks);

  always_comb begin
    t48    = iws_pkg::MEAN_W'(t_reg);
    tq_c   = (t48 > TQ_LIMIT) ? iws_pkg::MEAN_MAX : (t48 << FRAC_BITS);
    up_c   = tq_reg >= mean_acc;
    dabs_c = up_c ? (tq_reg - mean_acc) : (mean_acc - tq_reg);
    q_mean = div_quot[iws_pkg::MEAN_W-1:0];
    a_half = k[1] ? dabs[iws_pkg::MEAN_W-1:iws_pkg::HALF_W] : dabs[iws_pkg::HALF_W-1:0];
    b_half = k[0] ? eabs[iws_pkg::MEAN_W-1:iws_pkg::HALF_W] : eabs[iws_pkg::HALF_W-1:0];
    pk     = 2'(k - 3'd1);
    unique case (pk)
      2'd0:    part = iws_pkg::PROD_W'(prod);
      2'd1,
      2'd2:    part = iws_pkg::PROD_W'(prod) << iws_pkg::HALF_W;
      default: part = iws_pkg::PROD_W'(prod) << iws_pkg::MEAN_W;
    endcase
    inc_sat    = |acc[iws_pkg::PROD_W-1:INC_HI];
    inc        = inc_sat ? '1 : acc[INC_HI-1:FRAC_BITS];
    spread_sum = {1'b0, spread_acc} + {1'b0, inc};
    max48      = iws_pkg::MEAN_W'(max_seen);
  end

  always_comb begin
    if (state == iws_pkg::S_IDLE) begin
      div_dividend = spread_acc;
      div_divisor  = interval_count - iws_pkg::COUNT_W'(1);
    end else begin
      div_dividend = {dabs_c, iws_pkg::MEAN_PAD_W'(0)};
      div_divisor  = interval_count;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      iws_pkg::S_IDLE: begin
        if (accept) begin
          if (op == iws_pkg::OP_SAMPLE && clock_running) begin
            state_next = iws_pkg::S_PREP;
          end else if (op == iws_pkg::OP_REPORT) begin
            state_next = (interval_count > iws_pkg::COUNT_W'(1)) ? iws_pkg::S_VDIV
                                                                 : iws_pkg::S_EMIT;
          end
        end
      end
      iws_pkg::S_PREP: state_next = iws_pkg::S_DIFF;
      iws_pkg::S_DIFF: state_next = iws_pkg::S_MDIV;
      iws_pkg::S_MDIV: if (div_done) begin
        state_next = iws_pkg::S_MEAN;
      end
      iws_pkg::S_MEAN: state_next = iws_pkg::S_DEV;
      iws_pkg::S_DEV:  state_next = iws_pkg::S_MUL;
      iws_pkg::S_MUL:  if (k == 3'd4) begin
        state_next = iws_pkg::S_ACC;
      end
      iws_pkg::S_ACC:  state_next = iws_pkg::S_IDLE;
      iws_pkg::S_VDIV: if (div_done) begin
        state_next = iws_pkg::S_EMIT;
      end
      iws_pkg::S_EMIT: if (emit_go) begin
        state_next = iws_pkg::S_IDLE;
      end
      default: state_next = iws_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    events.ready  = state == iws_pkg::S_IDLE;
    emit_go       = (state == iws_pkg::S_EMIT) && (!stats_valid || stats.ready);
    div_cmd.start = 1'b0;
    div_cmd.steps = iws_pkg::MEAN_STEPS;
    if (state == iws_pkg::S_DIFF) begin
      div_cmd.start = 1'b1;
    end else if (accept && op == iws_pkg::OP_REPORT &&
                 interval_count > iws_pkg::COUNT_W'(1)) begin
      div_cmd.start = 1'b1;
      div_cmd.steps = iws_pkg::SPREAD_STEPS;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= iws_pkg::S_IDLE;
      clock_running  <= 1'b0;
      start_time     <= '0;
      interval_count <= '0;
      mean_acc       <= '0;
      spread_acc     <= '0;
      max_seen       <= '0;
      stats_valid    <= 1'b0;
    end else begin
      state <= state_next;
      if (emit_go) begin
        stats_valid <= 1'b1;
      end else if (stats_valid && stats.ready) begin
        stats_valid <= 1'b0;
      end
      unique case (state)
        iws_pkg::S_IDLE: begin
          if (accept) begin
            unique case (op)
              iws_pkg::OP_START: if (!clock_running) begin
                start_time    <= now_tw;
                clock_running <= 1'b1;
              end
              iws_pkg::OP_STOP: clock_running <= 1'b0;
              iws_pkg::OP_SAMPLE: if (clock_running) begin
                clock_running <= 1'b0;
                t_reg         <= now_tw - start_time;
                if (interval_count != iws_pkg::COUNT_MAX) begin
                  interval_count <= interval_count + iws_pkg::COUNT_W'(1);
                end
              end
              iws_pkg::OP_REPORT: ;
              default: ;
            endcase
          end
        end
        iws_pkg::S_PREP: begin
          tq_reg <= tq_c;
          if (t_reg > max_seen) begin
            max_seen <= t_reg;
          end
        end
        iws_pkg::S_DIFF: begin
          up   <= up_c;
          dabs <= dabs_c;
        end
        iws_pkg::S_MEAN: begin
          mean_acc <= up ? (mean_acc + q_mean) : (mean_acc - q_mean);
        end
        iws_pkg::S_DEV: begin
          eabs <= up ? (tq_reg - mean_acc) : (mean_acc - tq_reg);
          k    <= '0;
        end
        iws_pkg::S_MUL: begin
          prod <= a_half * b_half;
          acc  <= (k == 3'd0) ? '0 : acc + part;
          k    <= k + 3'd1;
        end
        iws_pkg::S_ACC: begin
          spread_acc <= spread_sum[iws_pkg::SPREAD_W] ? '1
                                                      : spread_sum[iws_pkg::SPREAD_W-1:0];
        end
        iws_pkg::S_EMIT: begin
          if (emit_go) begin
            stats.sample_count   <= interval_count;
            stats.mean_ticks     <= mean_acc;
            stats.variance_ticks <= (interval_count > iws_pkg::COUNT_W'(1)) ? div_quot : '0;
            stats.max_duration   <= (|max48[iws_pkg::MEAN_W-1:iws_pkg::MAX_W]) ? '1
                                    : max48[iws_pkg::MAX_W-1:0];
            interval_count       <= '0;
            mean_acc             <= '0;
            spread_acc           <= '0;
            max_seen             <= '0;
          end
        end
        default: ;
      endcase
    end
  end

  assign stats.valid = stats_valid;

  `IWS_ASSERT_NEXT(a_sample_stops_clock, accept && op == iws_pkg::OP_SAMPLE, !clock_running)
  `IWS_ASSERT_IMPLY(a_div_done_in_div, div_done, state == iws_pkg::S_MDIV || state == iws_pkg::S_VDIV)
  `IWS_ASSERT_NEXT(a_emit_clears, emit_go, interval_count == '0 && stats_valid)

endmodule

// File: verif/tb.sv
// Self-checking testbench for the interval statistics block with an internal predictor.
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import iws_pkg::*;

  localparam int HOLD_CYCLES = 3000;
  localparam int SETTLE_CYCLES = 100;
  localparam int TARGET_ITEMS = 1750;

  typedef struct packed {
    logic [COUNT_W-1:0]  sample_count;
    logic [MEAN_W-1:0]   mean_ticks;
    logic [SPREAD_W-1:0] variance_ticks;
    logic [MAX_W-1:0]    max_duration;
  } stats_beat_t;

  class interval_stats_board;
    logic [NOW_W-1:0]    start_time;
    bit                  running;
    logic [COUNT_W-1:0]  count;
    logic [MEAN_W-1:0]   mean;
    logic [SPREAD_W-1:0] spread;
    logic [MAX_W-1:0]    longest;
    stats_beat_t         pending_reports[$];
    int                  failures;
    int                  live_items;

    function new();
      start_time = '0;
      running = 1'b0;
      failures = 0;
      live_items = 0;
      clear_stats();
    endfunction

    function void clear_stats();
      count = '0;
      mean = '0;
      spread = '0;
      longest = '0;
    endfunction

    function void fold_interval(logic [NOW_W-1:0] now);
      logic [NOW_W-1:0]    dur;
      logic [63:0]         scaled;
      logic [MEAN_W-1:0]   tq;
      logic [MEAN_W-1:0]   dabs;
      logic [MEAN_W-1:0]   quot;
      logic [MEAN_W-1:0]   new_mean;
      logic [MEAN_W-1:0]   eabs;
      logic [PROD_W-1:0]   prod;
      logic [SPREAD_W-1:0] inc;
      logic [SPREAD_W:0]   sum;
      bit                  up;
      dur = now - start_time;
      scaled = {32'b0, dur} << FRAC_BITS_DEF;
      tq = (scaled > {16'b0, MEAN_MAX}) ? MEAN_MAX : scaled[MEAN_W-1:0];
      if (count != COUNT_MAX) count = count + 1'b1;
      up = tq >= mean;
      dabs = up ? tq - mean : mean - tq;
      quot = dabs / MEAN_W'(count);
      new_mean = up ? mean + quot : mean - quot;
      eabs = up ? tq - new_mean : new_mean - tq;
      mean = new_mean;
      prod = (PROD_W'(dabs) * PROD_W'(eabs)) >> FRAC_BITS_DEF;
      inc = (|prod[PROD_W-1:SPREAD_W]) ? '1 : prod[SPREAD_W-1:0];
      sum = {1'b0, spread} + {1'b0, inc};
      spread = sum[SPREAD_W] ? '1 : sum[SPREAD_W-1:0];
      if (dur > longest) longest = dur;
    endfunction

    function void note_event(logic [OPC_W-1:0] opcode, logic [NOW_W-1:0] now);
      stats_beat_t beat;
      live_items++;
      case (iws_op_t'(opcode))
        OP_START: begin
          if (!running) begin
            start_time = now;
            running = 1'b1;
          end
        end
        OP_STOP: begin
          running = 1'b0;
        end
        OP_SAMPLE: begin
          if (running) begin
            fold_interval(now);
            running = 1'b0;
          end
        end
        OP_REPORT: begin
          beat.sample_count = count;
          beat.mean_ticks = mean;
          beat.variance_ticks = (count > 1) ? spread / SPREAD_W'(count - 1'b1) : '0;
          beat.max_duration = longest;
          pending_reports.push_back(beat);
          clear_stats();
        end
        default: ;
      endcase
    endfunction

    function void check_report(stats_beat_t got);
      stats_beat_t want;
      if (pending_reports.size() == 0) begin
        failures++;
        if (failures <= 10)
          $display("unexpected report beat: count %0d mean %h var %h max %0d",
                   got.sample_count, got.mean_ticks, got.variance_ticks, got.max_duration);
        return;
      end
      want = pending_reports.pop_front();
      if (got.sample_count !== want.sample_count || got.mean_ticks !== want.mean_ticks ||
          got.variance_ticks !== want.variance_ticks ||
          got.max_duration !== want.max_duration) begin
        failures++;
        if (failures <= 10)
          $display("report mismatch: count %0d/%0d mean %h/%h var %h/%h max %0d/%0d",
                   want.sample_count, got.sample_count, want.mean_ticks, got.mean_ticks,
                   want.variance_ticks, got.variance_ticks, want.max_duration,
                   got.max_duration);
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst = 1'b1;
  bit   hold_request = 1'b0;
  int   burst_left = 0;

  iws_event_if ev();
  iws_stats_if st();

  interval_stats_board board = new();

  interval_welford_stats uut (
    .clk    (clk),
    .rst    (rst),
    .events (ev),
    .stats  (st)
  );

  always #1 clk = ~clk;

  always @(posedge clk) begin
    if (!rst) begin
      if (ev.valid && ev.ready) board.note_event(ev.opcode, ev.now_ticks);
      if (st.valid && st.ready)
        board.check_report(stats_beat_t'{st.sample_count, st.mean_ticks,
                                         st.variance_ticks, st.max_duration});
    end
  end

  initial begin
    #2_000_000;
    $display("CHECK FAILED");
    $finish;
  end

  initial begin
    int mode;
    int mode_left;
    mode = 0;
    mode_left = 0;
    st.ready <= 1'b0;
    wait (!rst);
    forever begin
      @(posedge clk);
      if (hold_request) begin
        st.ready <= 1'b0;
        repeat (HOLD_CYCLES - 1) @(posedge clk);
        hold_request = 1'b0;
      end else begin
        if (mode_left == 0) begin
          mode = $urandom_range(0, 2);
          mode_left = $urandom_range(50, 400);
        end
        mode_left--;
        case (mode)
          0: st.ready <= 1'b1;
          1: st.ready <= $urandom_range(0, 1);
          default: st.ready <= ($urandom_range(0, 7) == 0);
        endcase
      end
    end
  end

  task automatic send_event(iws_op_t opcode, logic [NOW_W-1:0] now);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 9) < 3) ? 0 : $urandom_range(1, 15);
      if (gap > 0) begin
        ev.valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 40);
    end
    burst_left--;
    ev.valid <= 1'b1;
    ev.opcode <= opcode;
    ev.now_ticks <= now;
    do @(posedge clk); while (!ev.ready);
  endtask

  task automatic drain();
    ev.valid <= 1'b0;
    burst_left = 0;
    @(posedge clk);
    while (board.pending_reports.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  function automatic logic [NOW_W-1:0] random_duration();
    int pick;
    pick = $urandom_range(0, 99);
    if (pick < 50) return $urandom_range(0, 255);
    if (pick < 80) return $urandom_range(0, 65535);
    if (pick < 95) return $urandom;
    return ($urandom_range(0, 1) == 1) ? '1 : '0;
  endfunction

  task automatic send_interval(bit with_report);
    logic [NOW_W-1:0] base;
    base = $urandom;
    send_event(OP_START, base);
    if ($urandom_range(0, 9) == 0) send_event(OP_START, $urandom);
    send_event(OP_SAMPLE, base + random_duration());
    if (with_report) send_event(OP_REPORT, $urandom);
  endtask

  initial begin
    int  pick;
    bit  squeezed;
    squeezed = 1'b0;
    ev.valid <= 1'b0;
    ev.opcode <= OP_START;
    ev.now_ticks <= '0;
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    send_event(OP_REPORT, 32'h0000_0000);
    send_event(OP_SAMPLE, 32'h0000_0000);
    send_event(OP_STOP, 32'hFFFF_FFFF);
    send_event(OP_START, 32'hFFFF_FFF0);
    send_event(OP_START, 32'h0000_0005);
    send_event(OP_SAMPLE, 32'h0000_0010);
    send_event(OP_REPORT, 32'hAAAA_AAAA);
    send_event(OP_START, 32'h0000_0000);
    send_event(OP_SAMPLE, 32'hFFFF_FFFF);
    send_event(OP_START, 32'h5555_5555);
    send_event(OP_SAMPLE, 32'h5555_5555);
    send_event(OP_START, 32'h0000_0001);
    send_event(OP_SAMPLE, 32'h0000_0000);
    send_event(OP_REPORT, 32'h0000_0000);
    send_event(OP_START, 32'h1234_5678);
    send_event(OP_STOP, 32'h1234_5679);
    send_event(OP_SAMPLE, 32'h1234_5680);
    send_event(OP_START, 32'h8000_0000);
    send_event(OP_REPORT, 32'h8000_0010);
    send_event(OP_SAMPLE, 32'h8000_0064);
    send_event(OP_STOP, 32'h8000_0065);
    send_event(OP_REPORT, 32'hFFFF_FFFF);
    send_event(OP_REPORT, 32'h7FFF_FFFF);
    drain();

    while (board.live_items < TARGET_ITEMS) begin
      if (!squeezed && board.live_items > 800) begin
        squeezed = 1'b1;
        hold_request = 1'b1;
        repeat (8) send_interval(1'b1);
        drain();
      end
      pick = $urandom_range(0, 99);
      if (pick < 75) begin
        send_interval($urandom_range(0, 5) == 0);
      end else if (pick < 85) begin
        send_event(OP_START, $urandom);
        send_event(OP_STOP, $urandom);
        send_event(OP_SAMPLE, $urandom);
      end else begin
        send_event(iws_op_t'($urandom_range(0, 3)), $urandom);
      end
      if ($urandom_range(0, 199) == 0) drain();
    end
    drain();

    if (board.failures == 0 && board.pending_reports.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end
endmodule
